// ===== hdl/dfsec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsec_pkg
// Shared types, sizes and codes for the depth-first search edge classifier.
// ----------------------------------------------------------------------------
package dfsec_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MAX_EDGES    = 1024;

   localparam int VID_W   = 9;                            // vertex id field
   localparam int VADDR_W = $clog2(MAX_VERTICES);         // per-vertex store address
   localparam int FS_AW   = $clog2(MAX_VERTICES + 1);     // first successor address
   localparam int VCNT_W  = $clog2(MAX_VERTICES + 2);     // vertex loop counter
   localparam int TOP_W   = $clog2(MAX_VERTICES + 1);     // stack depth
   localparam int EADDR_W = $clog2(MAX_EDGES);            // edge store address
   localparam int ECNT_W  = 11;                           // edge count field
   localparam int TIME_W  = 10;                           // time stamp field
   localparam int STK_W   = VID_W + 2 * ECNT_W;           // vertex, resume, end

   typedef enum logic [1:0] {
      MODE_LOAD     = 2'd0,
      MODE_RUN      = 2'd1,
      MODE_CLASSIFY = 2'd2,
      MODE_QUERY    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_NORUN = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CLS_TREE    = 2'd0,
      CLS_BACK    = 2'd1,
      CLS_FORWARD = 2'd2,
      CLS_CROSS   = 2'd3
   } class_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLR,
      S_BLD_V,
      S_BLD_RD,
      S_BLD_CMP,
      S_DR_RD,
      S_DR_CHK,
      S_ENT_A,
      S_ENT_B,
      S_STEP,
      S_EX_A,
      S_EX_B,
      S_EX_C,
      S_POP,
      S_CLS_A,
      S_CLS_B,
      S_QRY
   } state_type;

   typedef enum logic [4:0] {
      A_NONE,
      A_ACCEPT,
      A_CLR,
      A_BLD_V,
      A_BLD_RD,
      A_BLD_CMP,
      A_DR_RD,
      A_DR_CHK,
      A_ENT_A,
      A_ENT_B,
      A_STEP,
      A_EX_A,
      A_EX_B,
      A_EX_C,
      A_POP,
      A_CLS_A,
      A_CLS_B,
      A_QRY
   } act_type;

   typedef struct packed {
      act_type act;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic acc_err;
      logic clr_end;
      logic v_end;
      logic e_end;
      logic disc_zero;
      logic step_more;
      logic top_gt1;
   } stat_type;

   // id 1..n maps to store address 0..n-1
   function automatic logic [VADDR_W-1:0] vaddr(input logic [VID_W-1:0] id);
      logic [VID_W-1:0] t;
      t = id - VID_W'(1);
      return t[VADDR_W-1:0];
   endfunction

endpackage

// ===== hdl/dfsec_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsec channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfsec_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 mode;
   logic [dfsec_pkg::VID_W-1:0] origin;
   logic [dfsec_pkg::VID_W-1:0] dest;

   modport source (output valid, mode, origin, dest, input ready);
   modport sink   (input valid, mode, origin, dest, output ready);
endinterface

interface dfsec_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [1:0]                    edge_class;
   logic [dfsec_pkg::TIME_W-1:0]  discovery;
   logic [dfsec_pkg::TIME_W-1:0]  finish;
   logic [dfsec_pkg::VID_W-1:0]   parent_id;
   logic [dfsec_pkg::ECNT_W-1:0]  edge_total;

   modport source (output valid, status, edge_class, discovery, finish, parent_id,
                   edge_total, input ready);
   modport sink   (input valid, status, edge_class, discovery, finish, parent_id,
                   edge_total, output ready);
endinterface

// ===== hdl/dfsec_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsec_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dfsec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/dfsec_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsec_ctrl
// Sequencer for load, search run, classify and query transactions.
// ----------------------------------------------------------------------------
module dfsec_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   input  dfsec_pkg::stat_type stat,
   output logic                req_ready,
   output dfsec_pkg::cmd_type  cmd
);
   import dfsec_pkg::*;

   state_type state_ff, state_in;
   logic      fire;

   assign fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               unique case (mode_type'(req_mode))
                  MODE_LOAD:     state_in = S_IDLE;
                  MODE_RUN:      state_in = S_CLR;
                  MODE_CLASSIFY: state_in = stat.acc_err ? S_IDLE : S_CLS_A;
                  MODE_QUERY:    state_in = stat.acc_err ? S_IDLE : S_QRY;
                  default:       state_in = S_IDLE;
               endcase
            end
         end
         S_CLR:     state_in = stat.clr_end ? S_BLD_V : S_CLR;
         S_BLD_V:   state_in = stat.v_end ? S_DR_RD : S_BLD_RD;
         S_BLD_RD:  state_in = stat.e_end ? S_BLD_V : S_BLD_CMP;
         S_BLD_CMP: state_in = S_BLD_RD;
         S_DR_RD:   state_in = stat.v_end ? S_IDLE : S_DR_CHK;
         S_DR_CHK:  state_in = stat.disc_zero ? S_ENT_A : S_DR_RD;
         S_ENT_A:   state_in = S_ENT_B;
         S_ENT_B:   state_in = S_STEP;
         S_STEP: begin
            if (stat.step_more) begin
               state_in = S_EX_A;
            end else if (stat.top_gt1) begin
               state_in = S_POP;
            end else begin
               state_in = S_DR_RD;
            end
         end
         S_EX_A:    state_in = S_EX_B;
         S_EX_B:    state_in = S_EX_C;
         S_EX_C:    state_in = stat.disc_zero ? S_ENT_A : S_STEP;
         S_POP:     state_in = S_STEP;
         S_CLS_A:   state_in = S_CLS_B;
         S_CLS_B:   state_in = S_IDLE;
         S_QRY:     state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.act   = A_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.rsp_free;
            cmd.act   = fire ? A_ACCEPT : A_NONE;
         end
         S_CLR:     cmd.act = A_CLR;
         S_BLD_V:   cmd.act = A_BLD_V;
         S_BLD_RD:  cmd.act = A_BLD_RD;
         S_BLD_CMP: cmd.act = A_BLD_CMP;
         S_DR_RD:   cmd.act = A_DR_RD;
         S_DR_CHK:  cmd.act = A_DR_CHK;
         S_ENT_A:   cmd.act = A_ENT_A;
         S_ENT_B:   cmd.act = A_ENT_B;
         S_STEP:    cmd.act = A_STEP;
         S_EX_A:    cmd.act = A_EX_A;
         S_EX_B:    cmd.act = A_EX_B;
         S_EX_C:    cmd.act = A_EX_C;
         S_POP:     cmd.act = A_POP;
         S_CLS_A:   cmd.act = A_CLS_A;
         S_CLS_B:   cmd.act = A_CLS_B;
         S_QRY:     cmd.act = A_QRY;
         default:   cmd.act = A_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a run always walks through the clear pass first
   a_run_to_clr: assert property (@(posedge clock) disable iff (reset)
      (fire && mode_type'(req_mode) == MODE_RUN) |=> state_ff == S_CLR)
      else $error("run transaction did not start clear pass");

   // nothing is taken while busy
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("ready raised during a multi-cycle transaction");

   // ready only with room in the response register
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> stat.rsp_free)
      else $error("ready without response room");

endmodule

// ===== hdl/dfsec_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsec_dpath
// Edge store, adjacency build, search stack, vertex records and response.
// ----------------------------------------------------------------------------
module dfsec_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  dfsec_pkg::cmd_type              cmd,
   output dfsec_pkg::stat_type             stat,
   input  logic                            csr_write_en,
   input  logic [dfsec_pkg::VID_W-1:0]     csr_write_data,
   input  logic [1:0]                      req_mode,
   input  logic [dfsec_pkg::VID_W-1:0]     req_origin,
   input  logic [dfsec_pkg::VID_W-1:0]     req_dest,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [1:0]                      rsp_edge_class,
   output logic [dfsec_pkg::TIME_W-1:0]    rsp_discovery,
   output logic [dfsec_pkg::TIME_W-1:0]    rsp_finish,
   output logic [dfsec_pkg::VID_W-1:0]     rsp_parent_id,
   output logic [dfsec_pkg::ECNT_W-1:0]    rsp_edge_total
);
   import dfsec_pkg::*;

   localparam int DREC_W = TIME_W + VID_W;

   // control state
   logic [VID_W-1:0]  vt_ff, vt_in;
   logic [ECNT_W-1:0] edges_ff, edges_in;
   logic              done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [TIME_W-1:0] time_ff, time_in;

   // working registers
   logic [VCNT_W-1:0] vidx_ff, vidx_in;
   logic [ECNT_W-1:0] eidx_ff, eidx_in;
   logic [ECNT_W-1:0] k_ff, k_in;
   logic [VID_W-1:0]  cur_u_ff, cur_u_in;
   logic [ECNT_W-1:0] cur_p_ff, cur_p_in;
   logic [ECNT_W-1:0] cur_end_ff, cur_end_in;
   logic [VID_W-1:0]  o_ff, o_in;
   logic [VID_W-1:0]  d_ff, d_in;
   logic [TIME_W-1:0] disc_o_ff, disc_o_in;

   // response payload
   status_type        rs_status_ff, rs_status_in;
   class_type         rs_class_ff, rs_class_in;
   logic [TIME_W-1:0] rs_disc_ff, rs_disc_in;
   logic [TIME_W-1:0] rs_fin_ff, rs_fin_in;
   logic [VID_W-1:0]  rs_par_ff, rs_par_in;
   logic [ECNT_W-1:0] rs_total_ff, rs_total_in;

   // memory ports
   logic                    edge_we, edge_re;
   logic [EADDR_W-1:0]      edge_waddr, edge_raddr;
   logic [2*VID_W-1:0]      edge_wdata, edge_rdata;
   logic                    adj_we, adj_re;
   logic [EADDR_W-1:0]      adj_waddr, adj_raddr, adj_wdata, adj_rdata;
   logic                    fs_we, fs_re;
   logic [FS_AW-1:0]        fs_waddr, fs_raddr;
   logic [ECNT_W-1:0]       fs_wdata, fs_rdata;
   logic                    drec_we, drec_re;
   logic [VADDR_W-1:0]      drec_waddr, drec_raddr;
   logic [DREC_W-1:0]       drec_wdata, drec_rdata;
   logic                    fin_we, fin_re;
   logic [VADDR_W-1:0]      fin_waddr, fin_raddr;
   logic [TIME_W-1:0]       fin_wdata, fin_rdata;
   logic                    stk_we, stk_re;
   logic [VADDR_W-1:0]      stk_waddr, stk_raddr;
   logic [STK_W-1:0]        stk_wdata, stk_rdata;

   logic [VID_W-1:0]  live_n;
   logic              o_ok, d_ok;
   status_type        acc_status;
   logic [TIME_W-1:0] time_nx;
   logic [TIME_W-1:0] rd_disc;
   logic [VID_W-1:0]  rd_par;
   logic [VID_W-1:0]  e_from, e_to;
   logic [TOP_W-1:0]  top_m1, top_m2;
   logic              load_ok;

   assign live_n  = (vt_ff > VID_W'(MAX_VERTICES)) ? VID_W'(MAX_VERTICES) : vt_ff;
   assign o_ok    = (req_origin != '0) && (req_origin <= live_n);
   assign d_ok    = (req_dest != '0) && (req_dest <= live_n);
   assign time_nx = time_ff + TIME_W'(1);
   assign rd_disc = drec_rdata[DREC_W-1:VID_W];
   assign rd_par  = drec_rdata[VID_W-1:0];
   assign e_from  = edge_rdata[2*VID_W-1:VID_W];
   assign e_to    = edge_rdata[VID_W-1:0];
   assign top_m1  = top_ff - TOP_W'(1);
   assign top_m2  = top_ff - TOP_W'(2);

   always_comb begin
      acc_status = ST_OK;
      case (mode_type'(req_mode))
         MODE_LOAD: begin
            if (!(o_ok && d_ok)) begin
               acc_status = ST_RANGE;
            end else if (edges_ff >= ECNT_W'(MAX_EDGES)) begin
               acc_status = ST_FULL;
            end
         end
         MODE_CLASSIFY: begin
            if (!(o_ok && d_ok)) begin
               acc_status = ST_RANGE;
            end else if (!done_ff) begin
               acc_status = ST_NORUN;
            end
         end
         MODE_QUERY: begin
            if (!o_ok) begin
               acc_status = ST_RANGE;
            end else if (!done_ff) begin
               acc_status = ST_NORUN;
            end
         end
         default: acc_status = ST_OK;
      endcase
   end

   assign load_ok = (cmd.act == A_ACCEPT) && (mode_type'(req_mode) == MODE_LOAD) &&
                    (acc_status == ST_OK);

   always_comb begin
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
      stat.acc_err   = (acc_status != ST_OK);
      stat.clr_end   = (vidx_ff >= VCNT_W'(live_n));
      stat.v_end     = (vidx_ff > VCNT_W'(live_n));
      stat.e_end     = (eidx_ff >= edges_ff);
      stat.disc_zero = (rd_disc == '0);
      stat.step_more = (cur_p_ff < cur_end_ff);
      stat.top_gt1   = (top_ff > TOP_W'(1));
   end

   always_comb begin
      vt_in        = vt_ff;
      edges_in     = edges_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      top_in       = top_ff;
      time_in      = time_ff;
      vidx_in      = vidx_ff;
      eidx_in      = eidx_ff;
      k_in         = k_ff;
      cur_u_in     = cur_u_ff;
      cur_p_in     = cur_p_ff;
      cur_end_in   = cur_end_ff;
      o_in         = o_ff;
      d_in         = d_ff;
      disc_o_in    = disc_o_ff;
      rs_status_in = rs_status_ff;
      rs_class_in  = rs_class_ff;
      rs_disc_in   = rs_disc_ff;
      rs_fin_in    = rs_fin_ff;
      rs_par_in    = rs_par_ff;
      rs_total_in  = rs_total_ff;

      edge_we = 1'b0; edge_waddr = edges_ff[EADDR_W-1:0]; edge_wdata = {req_origin, req_dest};
      edge_re = 1'b0; edge_raddr = eidx_ff[EADDR_W-1:0];
      adj_we  = 1'b0; adj_waddr  = k_ff[EADDR_W-1:0];     adj_wdata  = eidx_ff[EADDR_W-1:0];
      adj_re  = 1'b0; adj_raddr  = cur_p_ff[EADDR_W-1:0];
      fs_we   = 1'b0; fs_waddr   = FS_AW'(vidx_ff - VCNT_W'(1)); fs_wdata = k_ff;
      fs_re   = 1'b0; fs_raddr   = FS_AW'(cur_u_ff);
      drec_we = 1'b0; drec_waddr = vidx_ff[VADDR_W-1:0];  drec_wdata = '0;
      drec_re = 1'b0; drec_raddr = vaddr(req_origin);
      fin_we  = 1'b0; fin_waddr  = vaddr(cur_u_ff);       fin_wdata  = time_nx;
      fin_re  = 1'b0; fin_raddr  = vaddr(req_origin);
      stk_we  = 1'b0; stk_waddr  = top_m1[VADDR_W-1:0];
      stk_wdata = {cur_u_ff, cur_p_ff, cur_end_ff};
      stk_re  = 1'b0; stk_raddr  = top_m2[VADDR_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         vt_in   = csr_write_data;
         done_in = 1'b0;
      end

      unique case (cmd.act)
         A_NONE: begin
         end
         A_ACCEPT: begin
            o_in         = req_origin;
            d_in         = req_dest;
            rs_status_in = acc_status;
            rs_class_in  = CLS_TREE;
            rs_disc_in   = '0;
            rs_fin_in    = '0;
            rs_par_in    = '0;
            rs_total_in  = edges_ff;
            case (mode_type'(req_mode))
               MODE_LOAD: begin
                  rsp_valid_in = 1'b1;
                  if (load_ok) begin
                     edge_we     = 1'b1;
                     edges_in    = edges_ff + ECNT_W'(1);
                     rs_total_in = edges_ff + ECNT_W'(1);
                     done_in     = 1'b0;
                  end
               end
               MODE_RUN: begin
                  vidx_in = '0;
               end
               default: begin
                  if (acc_status != ST_OK) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     drec_re = 1'b1;
                     fin_re  = 1'b1;
                  end
               end
            endcase
         end
         A_CLR: begin
            if (vidx_ff < VCNT_W'(live_n)) begin
               drec_we    = 1'b1;
               drec_waddr = vidx_ff[VADDR_W-1:0];
               drec_wdata = '0;
               vidx_in    = vidx_ff + VCNT_W'(1);
            end else begin
               vidx_in = VCNT_W'(1);
               k_in    = '0;
            end
         end
         A_BLD_V: begin
            // also writes the end marker one past the last vertex
            fs_we   = 1'b1;
            eidx_in = '0;
            if (vidx_ff > VCNT_W'(live_n)) begin
               vidx_in = VCNT_W'(1);
               time_in = '0;
            end
         end
         A_BLD_RD: begin
            if (eidx_ff < edges_ff) begin
               edge_re = 1'b1;
            end else begin
               vidx_in = vidx_ff + VCNT_W'(1);
            end
         end
         A_BLD_CMP: begin
            if ((VCNT_W'(e_from) == vidx_ff) && (e_to != '0) && (e_to <= live_n)) begin
               adj_we = 1'b1;
               k_in   = k_ff + ECNT_W'(1);
            end
            eidx_in = eidx_ff + ECNT_W'(1);
         end
         A_DR_RD: begin
            if (vidx_ff > VCNT_W'(live_n)) begin
               done_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rs_status_in = ST_OK;
               rs_class_in  = CLS_TREE;
               rs_disc_in   = '0;
               rs_fin_in    = '0;
               rs_par_in    = '0;
               rs_total_in  = edges_ff;
            end else begin
               drec_re    = 1'b1;
               drec_raddr = vaddr(VID_W'(vidx_ff));
            end
         end
         A_DR_CHK: begin
            if (rd_disc == '0) begin
               time_in    = time_nx;
               drec_we    = 1'b1;
               drec_waddr = vaddr(VID_W'(vidx_ff));
               drec_wdata = {time_nx, VID_W'(0)};
               cur_u_in   = VID_W'(vidx_ff);
               top_in     = TOP_W'(1);
               fs_re      = 1'b1;
               fs_raddr   = FS_AW'(vaddr(VID_W'(vidx_ff)));
            end else begin
               vidx_in = vidx_ff + VCNT_W'(1);
            end
         end
         A_ENT_A: begin
            cur_p_in = fs_rdata;
            fs_re    = 1'b1;
            fs_raddr = FS_AW'(cur_u_ff);
         end
         A_ENT_B: begin
            cur_end_in = fs_rdata;
         end
         A_STEP: begin
            if (cur_p_ff < cur_end_ff) begin
               adj_re   = 1'b1;
               cur_p_in = cur_p_ff + ECNT_W'(1);
            end else begin
               time_in = time_nx;
               fin_we  = 1'b1;
               top_in  = top_m1;
               if (top_ff > TOP_W'(1)) begin
                  stk_re = 1'b1;
               end else begin
                  vidx_in = vidx_ff + VCNT_W'(1);
               end
            end
         end
         A_EX_A: begin
            edge_re    = 1'b1;
            edge_raddr = adj_rdata;
         end
         A_EX_B: begin
            d_in       = e_to;
            drec_re    = 1'b1;
            drec_raddr = vaddr(e_to);
         end
         A_EX_C: begin
            if (rd_disc == '0) begin
               stk_we     = 1'b1;
               top_in     = top_ff + TOP_W'(1);
               time_in    = time_nx;
               drec_we    = 1'b1;
               drec_waddr = vaddr(d_ff);
               drec_wdata = {time_nx, cur_u_ff};
               cur_u_in   = d_ff;
               fs_re      = 1'b1;
               fs_raddr   = FS_AW'(vaddr(d_ff));
            end
         end
         A_POP: begin
            {cur_u_in, cur_p_in, cur_end_in} = stk_rdata;
         end
         A_CLS_A: begin
            disc_o_in  = rd_disc;
            drec_re    = 1'b1;
            drec_raddr = vaddr(d_ff);
            fin_re     = 1'b1;
            fin_raddr  = vaddr(d_ff);
         end
         A_CLS_B: begin
            rsp_valid_in = 1'b1;
            if (disc_o_ff < rd_disc) begin
               rs_class_in = (rd_par == o_ff) ? CLS_TREE : CLS_FORWARD;
            end else if (fin_rdata < disc_o_ff) begin
               rs_class_in = CLS_CROSS;
            end else begin
               rs_class_in = CLS_BACK;
            end
         end
         A_QRY: begin
            rsp_valid_in = 1'b1;
            rs_disc_in   = rd_disc;
            rs_fin_in    = fin_rdata;
            rs_par_in    = rd_par;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff        <= '0;
         edges_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         top_ff       <= '0;
         time_ff      <= '0;
      end else begin
         vt_ff        <= vt_in;
         edges_ff     <= edges_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         time_ff      <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      vidx_ff      <= vidx_in;
      eidx_ff      <= eidx_in;
      k_ff         <= k_in;
      cur_u_ff     <= cur_u_in;
      cur_p_ff     <= cur_p_in;
      cur_end_ff   <= cur_end_in;
      o_ff         <= o_in;
      d_ff         <= d_in;
      disc_o_ff    <= disc_o_in;
      rs_status_ff <= rs_status_in;
      rs_class_ff  <= rs_class_in;
      rs_disc_ff   <= rs_disc_in;
      rs_fin_ff    <= rs_fin_in;
      rs_par_ff    <= rs_par_in;
      rs_total_ff  <= rs_total_in;
   end

   dfsec_ram #(.WIDTH(2 * VID_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata));

   dfsec_ram #(.WIDTH(EADDR_W), .DEPTH(MAX_EDGES)) u_adj_ram (
      .clock(clock), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
      .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata));

   dfsec_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_VERTICES + 1)) u_fs_ram (
      .clock(clock), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
      .re(fs_re), .raddr(fs_raddr), .rdata(fs_rdata));

   dfsec_ram #(.WIDTH(DREC_W), .DEPTH(MAX_VERTICES)) u_drec_ram (
      .clock(clock), .we(drec_we), .waddr(drec_waddr), .wdata(drec_wdata),
      .re(drec_re), .raddr(drec_raddr), .rdata(drec_rdata));

   dfsec_ram #(.WIDTH(TIME_W), .DEPTH(MAX_VERTICES)) u_fin_ram (
      .clock(clock), .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
      .re(fin_re), .raddr(fin_raddr), .rdata(fin_rdata));

   dfsec_ram #(.WIDTH(STK_W), .DEPTH(MAX_VERTICES)) u_stk_ram (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rs_status_ff;
   assign rsp_edge_class = rs_class_ff;
   assign rsp_discovery  = rs_disc_ff;
   assign rsp_finish     = rs_fin_ff;
   assign rsp_parent_id  = rs_par_ff;
   assign rsp_edge_total = rs_total_ff;

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(MAX_VERTICES))
      else $error("search stack overflow");

   a_time_bound: assert property (@(posedge clock) disable iff (reset)
      time_ff <= TIME_W'(2 * MAX_VERTICES))
      else $error("time counter beyond two stamps per vertex");

   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= ECNT_W'(MAX_EDGES))
      else $error("edge count beyond store size");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      load_ok |=> (edges_ff == $past(edges_ff) + ECNT_W'(1)) && !done_ff)
      else $error("stored edge not counted");

endmodule

// ===== hdl/dfs_edge_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_edge_classifier_top
// Depth-first search edge classifier: controller plus datapath.
// ----------------------------------------------------------------------------
// Load: response registered at the accept edge. Query: reads issued at accept.
// Classify: two reads of the vertex record memory.
// Run: clear pass, then adjacency build (each vertex scans the edge store), then
// the search walk.
// One transaction in flight; the next is taken once the waiting response leaves.
// Reset: control cleared, vertex_total 0, no edges, search not yet run.
module dfs_edge_classifier_top (
   input  logic                        clock,
   input  logic                        reset,
   dfsec_req_if.sink                   req_ch,
   dfsec_rsp_if.source                 rsp_ch,
   input  logic                        csr_write_en,
   input  logic [dfsec_pkg::VID_W-1:0] csr_write_data
);
   import dfsec_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dfsec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .stat      (stat),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   dfsec_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_mode       (req_ch.mode),
      .req_origin     (req_ch.origin),
      .req_dest       (req_ch.dest),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_status     (rsp_ch.status),
      .rsp_edge_class (rsp_ch.edge_class),
      .rsp_discovery  (rsp_ch.discovery),
      .rsp_finish     (rsp_ch.finish),
      .rsp_parent_id  (rsp_ch.parent_id),
      .rsp_edge_total (rsp_ch.edge_total)
   );

endmodule

// ===== verif/tb_dfs_edge_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dfs_edge_classifier_top
// Drives edge loads, searches, classifications and vertex queries through the
// request channel, predicts each response with a behavioral depth-first
// search and compares every response field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_dfs_edge_classifier_top;
   import dfsec_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000000;

   typedef struct {
      status_type   st;
      class_type    cls;
      logic [9:0]   disc;
      logic [9:0]   fin;
      logic [8:0]   par;
      logic [10:0]  etot;
   } dfs_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [VID_W-1:0] csr_write_data;

   dfsec_req_if req_bus();
   dfsec_rsp_if rsp_bus();

   dfs_edge_classifier_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #4 clock = ~clock;

   // shadow copy of the block's state
   int        vtx_total;
   int        edge_src [MAX_EDGES];
   int        edge_dst [MAX_EDGES];
   int        edges_held;
   int        adj_list [MAX_EDGES];
   int        succ_base [MAX_VERTICES + 2];
   int        disc_t [MAX_VERTICES + 1];
   int        fin_t [MAX_VERTICES + 1];
   int        par_v [MAX_VERTICES + 1];
   int        stk_v [MAX_VERTICES];
   int        stk_r [MAX_VERTICES];
   bit        searched;

   dfs_rsp_type pending_rsp[$];
   int        mismatches = 0;
   bit        steady = 1'b0;
   int        quiet_cycles = 0;

   function automatic int live_n();
      return (vtx_total > MAX_VERTICES) ? MAX_VERTICES : vtx_total;
   endfunction

   function automatic bit id_valid(int id);
      return id >= 1 && id <= live_n();
   endfunction

   function automatic void walk_graph();
      int n, k, top, u, p, w;
      n = live_n();
      k = 0;
      for (int i = 0; i <= MAX_VERTICES; i++) begin
         disc_t[i] = 0; fin_t[i] = 0; par_v[i] = 0;
      end
      for (int i = 0; i < MAX_VERTICES + 2; i++) succ_base[i] = 0;
      for (int v = 1; v <= n; v++) begin
         succ_base[v] = k;
         for (int e = 0; e < edges_held; e++)
            if (edge_src[e] == v && edge_dst[e] >= 1 && edge_dst[e] <= n) begin
               adj_list[k] = e;
               k++;
            end
      end
      succ_base[n + 1] = k;
      begin
         int clk_t;
         clk_t = 0;
         for (int v = 1; v <= n; v++) begin
            if (disc_t[v] != 0) continue;
            clk_t++;
            disc_t[v] = clk_t;
            stk_v[0] = v;
            stk_r[0] = succ_base[v];
            top = 1;
            while (top > 0) begin
               u = stk_v[top - 1];
               p = stk_r[top - 1];
               if (p < succ_base[u + 1] && p < MAX_EDGES) begin
                  w = edge_dst[adj_list[p]];
                  stk_r[top - 1] = p + 1;
                  if (w <= MAX_VERTICES && disc_t[w] == 0 && top < MAX_VERTICES) begin
                     par_v[w] = u;
                     clk_t++;
                     disc_t[w] = clk_t;
                     stk_v[top] = w;
                     stk_r[top] = succ_base[w];
                     top++;
                  end
               end else begin
                  top--;
                  clk_t++;
                  fin_t[u] = clk_t;
               end
            end
         end
      end
      searched = 1'b1;
   endfunction

   function automatic dfs_rsp_type predict_rsp(mode_type m, int o, int d);
      dfs_rsp_type r;
      r.st = ST_OK; r.cls = CLS_TREE; r.disc = '0; r.fin = '0; r.par = '0;
      case (m)
         MODE_LOAD: begin
            if (!id_valid(o) || !id_valid(d)) r.st = ST_RANGE;
            else if (edges_held >= MAX_EDGES) r.st = ST_FULL;
            else begin
               edge_src[edges_held] = o;
               edge_dst[edges_held] = d;
               edges_held++;
               searched = 1'b0;
            end
         end
         MODE_RUN: walk_graph();
         MODE_CLASSIFY: begin
            if (!id_valid(o) || !id_valid(d)) r.st = ST_RANGE;
            else if (!searched) r.st = ST_NORUN;
            else if (disc_t[o] < disc_t[d]) r.cls = (par_v[d] == o) ? CLS_TREE : CLS_FORWARD;
            else if (fin_t[d] < disc_t[o]) r.cls = CLS_CROSS;
            else r.cls = CLS_BACK;
         end
         default: begin
            if (!id_valid(o)) r.st = ST_RANGE;
            else if (!searched) r.st = ST_NORUN;
            else begin
               r.disc = 10'(disc_t[o]);
               r.fin = 10'(fin_t[o]);
               r.par = 9'(par_v[o]);
            end
         end
      endcase
      r.etot = 11'(edges_held);
      return r;
   endfunction

   task automatic send_req(mode_type m, int o, int d);
      if (!steady && $urandom_range(0, 99) < 12) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= m;
      req_bus.origin <= o[8:0];
      req_bus.dest   <= d[8:0];
      do @(posedge clock); while (!req_bus.ready);
      pending_rsp.push_back(predict_rsp(m, o, d));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_vertex_total(int value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value[8:0];
      @(posedge clock);
      csr_write_en   <= 1'b0;
      vtx_total = value;
      searched  = 1'b0;
      @(posedge clock);
   endtask

   // response checker and sink stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response transaction");
            end else begin
               dfs_rsp_type x;
               x = pending_rsp.pop_front();
               if (rsp_bus.status !== x.st || rsp_bus.edge_class !== x.cls ||
                   rsp_bus.discovery !== x.disc || rsp_bus.finish !== x.fin ||
                   rsp_bus.parent_id !== x.par || rsp_bus.edge_total !== x.etot) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp st%0d c%0d d%0d f%0d p%0d e%0d got st%0d c%0d d%0d f%0d p%0d e%0d",
                              x.st, x.cls, x.disc, x.fin, x.par, x.etot,
                              rsp_bus.status, rsp_bus.edge_class, rsp_bus.discovery,
                              rsp_bus.finish, rsp_bus.parent_id, rsp_bus.edge_total);
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 12);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dfs_edge_classifier_top verification failed");
         $finish;
      end
   end

   task automatic test_before_config();
      send_req(MODE_QUERY, 1, 0);
      send_req(MODE_CLASSIFY, 1, 1);
      send_req(MODE_LOAD, 0, 0);
      send_req(MODE_RUN, 0, 0);
      send_req(MODE_QUERY, 0, 0);
   endtask

   task automatic test_small_graph();
      write_vertex_total(5);
      send_req(MODE_QUERY, 1, 0);        // search not yet run
      send_req(MODE_LOAD, 1, 2);
      send_req(MODE_LOAD, 2, 3);
      send_req(MODE_LOAD, 3, 1);
      send_req(MODE_LOAD, 1, 3);
      send_req(MODE_LOAD, 4, 2);
      send_req(MODE_LOAD, 5, 5);
      send_req(MODE_LOAD, 0, 2);
      send_req(MODE_LOAD, 6, 1);
      send_req(MODE_LOAD, 511, 511);
      send_req(MODE_CLASSIFY, 1, 2);
      send_req(MODE_RUN, 511, 511);
      send_req(MODE_CLASSIFY, 1, 2);     // tree
      send_req(MODE_CLASSIFY, 3, 1);     // back
      send_req(MODE_CLASSIFY, 1, 3);     // forward
      send_req(MODE_CLASSIFY, 4, 2);     // cross
      send_req(MODE_CLASSIFY, 5, 5);     // self loop
      send_req(MODE_CLASSIFY, 2, 6);
      for (int v = 1; v <= 5; v++) send_req(MODE_QUERY, v, 0);
      send_req(MODE_QUERY, 511, 0);
      send_req(MODE_LOAD, 2, 4);         // load after run drops the result
      send_req(MODE_QUERY, 2, 0);
   endtask

   task automatic test_random_graphs();
      int n, loads, asks, r;
      for (int ph = 0; ph < 12; ph++) begin
         steady = (ph == 3);
         if (ph == 1) n = 256;
         else if (ph == 2) n = 511;
         else if (ph == 4) n = 1;
         else n = $urandom_range(2, 12);
         write_vertex_total(n);
         loads = (n > 12) ? 60 : $urandom_range(4, 25);
         for (int i = 0; i < loads; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_req(mode_type'($urandom_range(0, 3)), $urandom_range(0, 511),
                        $urandom_range(0, 511));
            else
               send_req(MODE_LOAD, $urandom_range(1, live_n()), $urandom_range(1, live_n()));
         end
         send_req(MODE_RUN, $urandom_range(0, 511), $urandom_range(0, 511));
         asks = 45;
         for (int i = 0; i < asks; i++) begin
            r = $urandom_range(0, 19);
            if (r < 9)
               send_req(MODE_CLASSIFY, $urandom_range(1, live_n()), $urandom_range(1, live_n()));
            else if (r < 17)
               send_req(MODE_QUERY, $urandom_range(1, live_n()), $urandom_range(0, 511));
            else
               send_req(mode_type'($urandom_range(0, 3)), $urandom_range(0, 511),
                        $urandom_range(0, 511));
         end
         // shrink the vertex count so stored edges go stale
         if (ph == 6) begin
            write_vertex_total(3);
            send_req(MODE_RUN, 0, 0);
            for (int v = 1; v <= 4; v++) send_req(MODE_QUERY, v, 0);
            send_req(MODE_CLASSIFY, 1, 2);
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_full_store();
      write_vertex_total(8);
      while (edges_held < MAX_EDGES)
         send_req(MODE_LOAD, $urandom_range(1, 8), $urandom_range(1, 8));
      send_req(MODE_LOAD, 8, 1);
      send_req(MODE_LOAD, 1, 9);
      send_req(MODE_RUN, 0, 0);
      for (int v = 1; v <= 8; v++) send_req(MODE_QUERY, v, 0);
      send_req(MODE_CLASSIFY, 8, 1);
      write_vertex_total(0);
      send_req(MODE_QUERY, 1, 0);
   endtask

   initial begin
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.mode   <= MODE_LOAD;
      req_bus.origin <= '0;
      req_bus.dest   <= '0;
      vtx_total  = 0;
      edges_held = 0;
      searched   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_config();
      test_small_graph();
      test_random_graphs();
      test_full_store();
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("dfs_edge_classifier_top verification clean");
      else
         $display("dfs_edge_classifier_top verification failed");
      $finish;
   end

endmodule
